// File: sv/b64enc_pkg.sv
// Shared types, constants and the alphabet map for the base64 encoder.
// No dependencies; every other file in sv/ imports this package.
package b64enc_pkg;

  // Pad character '=' and queue sizing
  localparam logic [7:0] PAD_CHAR    = 8'h3D;
  localparam int         QUEUE_DEPTH = 2;
  localparam int         QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int         QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Group byte counts
  localparam logic [1:0] CNT_ONE   = 2'd1;
  localparam logic [1:0] CNT_TWO   = 2'd2;
  localparam logic [1:0] CNT_THREE = 2'd3;

  // Phase codes: bytes held for the current group
  localparam logic [1:0] PH_EMPTY = 2'd0;
  localparam logic [1:0] PH_ONE   = 2'd1;
  localparam logic [1:0] PH_TWO   = 2'd2;

  // Input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [7:0] char_first;
    logic [7:0] char_second;
    logic [7:0] char_third;
    logic [7:0] char_fourth;
    logic       final_group;
  } out_word_t;

  // Group handed from front to back: raw bits, byte count, last flag
  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  count;
    logic        last;
  } group_t;

  // Map one sextet to its alphabet character
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    begin
      c = 8'h00;
      if (v < 6'd26) begin
        c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
        c = 8'h61 + {2'b00, v - 6'd26};
      end else if (v < 6'd62) begin
        c = 8'h30 + {2'b00, v - 6'd52};
      end else if (v == 6'd62) begin
        c = 8'h2B;
      end else begin
        c = 8'h2F;
      end
      return c;
    end
  endfunction

endpackage

// File: sv/b64enc_front.sv
// Front end of the base64 encoder: accepts bytes, gathers them into groups.
// Depends on b64enc_pkg; pushes finished groups into b64enc_queue.
module b64enc_front
  import b64enc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  logic     q_full,
  output logic     q_push,
  output group_t   q_data
);

  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] pend_r, pend_nxt;
  logic [1:0]  phase;
  logic        accept;
  logic [7:0]  b;
  logic        eos;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_word.data_byte;
  assign eos      = in_word.end_of_stream;
  // Unreachable phase three behaves as empty
  assign phase    = (phase_r == 2'd3) ? PH_EMPTY : phase_r;

  // Classify the byte: hold it or close a group
  always_comb begin
    phase_nxt    = phase_r;
    pend_nxt     = pend_r;
    q_push       = 1'b0;
    q_data.bits  = {pend_r, b};
    q_data.count = CNT_THREE;
    q_data.last  = eos;
    case (phase)
      PH_EMPTY: begin
        q_data.bits  = {b, 16'h0000};
        q_data.count = CNT_ONE;
      end
      PH_ONE: begin
        q_data.bits  = {pend_r[15:8], b, 8'h00};
        q_data.count = CNT_TWO;
      end
      default: begin
        q_data.bits  = {pend_r, b};
        q_data.count = CNT_THREE;
      end
    endcase
    if (accept) begin
      if (eos || phase == PH_TWO) begin
        q_push    = 1'b1;
        phase_nxt = PH_EMPTY;
        pend_nxt  = 16'h0000;
      end else if (phase == PH_EMPTY) begin
        phase_nxt = PH_ONE;
        pend_nxt  = {b, 8'h00};
      end else begin
        phase_nxt = PH_TWO;
        pend_nxt  = {pend_r[15:8], b};
      end
    end
  end

  // Hold phase and pending bytes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_EMPTY;
      pend_r  <= 16'h0000;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

// File: sv/b64enc_queue.sv
// Short group queue between the front and back of the base64 encoder.
// Depends on b64enc_pkg for the group type and depth.
module b64enc_queue
  import b64enc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  group_t push_data,
  output logic   full,
  input  logic   pop,
  output group_t pop_data,
  output logic   empty
);

  group_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem[rd_ptr_r];

  // Store a pushed group
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: sv/b64enc_back.sv
// Back end of the base64 encoder: maps a group to characters, registers it.
// Depends on b64enc_pkg; pops groups from b64enc_queue.
module b64enc_back
  import b64enc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_empty,
  input  group_t    q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic      out_valid_r;
  out_word_t out_word_r, out_word_nxt;

  // Take a group when the output register is free or being drained
  assign q_pop = !q_empty && (!out_valid_r || !out_stall);

  // Map sextets, pad short groups
  always_comb begin
    out_word_nxt.char_first  = sextet_char(q_data.bits[23:18]);
    out_word_nxt.char_second = sextet_char(q_data.bits[17:12]);
    out_word_nxt.char_third  = (q_data.count >= CNT_TWO) ?
                               sextet_char(q_data.bits[11:6]) : PAD_CHAR;
    out_word_nxt.char_fourth = (q_data.count == CNT_THREE) ?
                               sextet_char(q_data.bits[5:0]) : PAD_CHAR;
    out_word_nxt.final_group = q_data.last;
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_word_r <= out_word_nxt;
    end
  end

  // Track output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: sv/base64_encoder.sv
// Top level of the streaming base64 encoder (standard alphabet, '=' padding).
// Depends on b64enc_pkg, b64enc_front, b64enc_queue and b64enc_back.
//
//   port group  | direction | word type  | meaning
//   in_         | input     | in_word_t  | one raw byte, flag on final byte
//   out_        | output    | out_word_t | four characters, flag on last group
//
// One byte is taken each cycle while the queue is not full. A group is written
// into the queue when its last byte is taken, and it loads the output register,
// raising out_valid, once that register is free or being drained; older groups
// waiting in the queue go first. The front stalls only when the two-entry queue is full.
// Reset (rst_n low, synchronous) clears the phase, the queue and output valid.
// A stalled output holds its word; the front keeps taking bytes until the
// queue fills.
module base64_encoder
  import b64enc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic   q_full, q_empty, q_push, q_pop;
  group_t q_wdata, q_rdata;

  b64enc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  b64enc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  b64enc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
